// ===== hw/rtl/elevator_request_controller_core_macros.svh =====
// Assertion helpers used by erc_event_core.
`ifndef ELEVATOR_REQUEST_CONTROLLER_CORE_MACROS_SVH
`define ELEVATOR_REQUEST_CONTROLLER_CORE_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ERC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ERC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/erc_pkg.sv =====
`default_nettype none
package erc_pkg;

	localparam int FLD_W  = 5;
	localparam int KIND_W = 3;
	localparam int CMD_W  = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_PRESS   = 3'd0,
		KIND_MOVING  = 3'd1,
		KIND_STOPPED = 3'd2,
		KIND_OPENED  = 3'd3,
		KIND_TIMEOUT = 3'd4
	} kind_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_NONE  = 3'd0,
		CMD_OPEN  = 3'd1,
		CMD_CLOSE = 3'd2,
		CMD_STOP  = 3'd3,
		CMD_MOVE  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE        = 3'd0,
		ST_DETERMINE   = 3'd1,
		ST_WAIT_ARRIVE = 3'd3,
		ST_ARRIVED     = 3'd4,
		ST_WAIT_PASS   = 3'd5,
		ST_CLOSING     = 3'd6
	} ctrl_state_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [FLD_W-1:0]  pressed_floor;
		logic [FLD_W-1:0]  current_floor;
		logic              direction_down;
	} erc_item_t;

	typedef struct packed {
		cmd_t             command;
		logic [FLD_W-1:0] target_floor;
		logic [FLD_W-1:0] release_floor;
		logic             start_timer;
		logic             stop_timer;
	} erc_result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/erc_target_search.sv =====
`default_nettype none
module erc_target_search #(
	parameter int FLOORS = 16
) (
	input  wire logic [FLOORS-1:0]                  req,
	input  wire logic [$clog2(FLOORS)-1:0]          cur_idx,
	input  wire logic                               down,
	output logic      [$clog2(FLOORS+1)-1:0]        target
);
	localparam int IW = $clog2(FLOORS);
	localparam int FW = $clog2(FLOORS + 1);

	logic [FW-1:0] up_t;
	logic [FW-1:0] dn_t;

	always_comb begin
		up_t = '0;
		dn_t = '0;
		for (int i = FLOORS - 1; i >= 0; i--) begin
			if (req[i] && (IW'(i) >= cur_idx)) begin
				up_t = FW'(i + 1);
			end
		end
		for (int i = 0; i < FLOORS; i++) begin
			if (req[i] && (IW'(i) <= cur_idx)) begin
				dn_t = FW'(i + 1);
			end
		end
	end

	always_comb begin
		if (down) begin
			target = (dn_t != '0) ? dn_t : up_t;
		end else begin
			target = (up_t != '0) ? up_t : dn_t;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/erc_event_core.sv =====
`default_nettype none
`include "elevator_request_controller_core_macros.svh"
module erc_event_core #(
	parameter int FLOORS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire erc_pkg::erc_item_t  item,
	output erc_pkg::erc_result_t     res
);
	import erc_pkg::*;

	localparam int IW = $clog2(FLOORS);
	localparam int FW = $clog2(FLOORS + 1);
	localparam int CW = (FW > FLD_W) ? FW : FLD_W;

	ctrl_state_t       state_q;
	ctrl_state_t       state_d;
	logic [FLOORS-1:0] req_q;
	logic [FLOORS-1:0] req_d;

	logic [CW-1:0]     cur_w;
	logic [CW-1:0]     cur_c;
	logic [CW-1:0]     prs_w;
	logic [IW-1:0]     cur_idx;
	logic [IW-1:0]     pidx;
	logic              press_ok;
	logic [FLOORS-1:0] pbit;
	logic [FLOORS-1:0] cbit;
	logic [FLOORS-1:0] search_req;
	logic [FW-1:0]     tgt;

	always_comb begin
		cur_w = CW'(item.current_floor);
		prs_w = CW'(item.pressed_floor);
		if (cur_w == '0) begin
			cur_c = CW'(1);
		end else if (cur_w > CW'(FLOORS)) begin
			cur_c = CW'(FLOORS);
		end else begin
			cur_c = cur_w;
		end
		cur_idx  = IW'(cur_c - CW'(1));
		pidx     = IW'(prs_w - CW'(1));
		press_ok = (prs_w != '0) && (prs_w <= CW'(FLOORS));
		pbit       = '0;
		pbit[pidx] = 1'b1;
		cbit          = '0;
		cbit[cur_idx] = 1'b1;
		search_req = (item.kind == KIND_PRESS) ? (req_q | pbit) : req_q;
	end

	erc_target_search #(
		.FLOORS(FLOORS)
	) u_search (
		.req     (search_req),
		.cur_idx (cur_idx),
		.down    (item.direction_down),
		.target  (tgt)
	);

	always_comb begin
		state_d = state_q;
		req_d   = req_q;
		if (fire) begin
			unique case (item.kind)
				KIND_PRESS: begin
					if (press_ok) begin
						state_d = ST_DETERMINE;
						req_d   = req_q | pbit;
					end
				end
				KIND_MOVING: begin
					state_d = ST_WAIT_ARRIVE;
				end
				KIND_STOPPED: begin
					if (state_q == ST_WAIT_ARRIVE || state_q == ST_DETERMINE) begin
						state_d = ST_ARRIVED;
					end
				end
				KIND_OPENED: begin
					if (state_q == ST_CLOSING || state_q == ST_ARRIVED ||
					    state_q == ST_DETERMINE) begin
						state_d = ST_WAIT_PASS;
						req_d   = req_q & ~cbit;
					end
				end
				KIND_TIMEOUT: begin
					if (state_q == ST_WAIT_PASS || state_q == ST_DETERMINE) begin
						state_d = ST_CLOSING;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res = '{command: CMD_NONE, target_floor: '0, release_floor: '0,
		        start_timer: 1'b0, stop_timer: 1'b0};
		unique case (item.kind)
			KIND_PRESS: begin
				if (press_ok && ((req_q == '0) || (prs_w == cur_c))) begin
					res.command      = CMD_OPEN;
					res.target_floor = FLD_W'(tgt);
				end
			end
			KIND_MOVING: begin
				if (req_q[cur_idx]) begin
					res.command = CMD_STOP;
				end else if (tgt != '0) begin
					res.command      = CMD_MOVE;
					res.target_floor = FLD_W'(tgt);
				end
			end
			KIND_STOPPED: begin
				if (state_q == ST_WAIT_ARRIVE || state_q == ST_DETERMINE) begin
					res.command = CMD_OPEN;
				end
			end
			KIND_OPENED: begin
				if (state_q == ST_CLOSING || state_q == ST_ARRIVED ||
				    state_q == ST_DETERMINE) begin
					res.release_floor = FLD_W'(cur_c);
					res.start_timer   = 1'b1;
				end
			end
			KIND_TIMEOUT: begin
				if (state_q == ST_WAIT_PASS || state_q == ST_DETERMINE) begin
					res.command    = CMD_CLOSE;
					res.stop_timer = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_q   <= '0;
		end else begin
			state_q <= state_d;
			req_q   <= req_d;
		end
	end

	`ERC_ASSERT(a_hold_when_idle, !fire |=> $stable(state_q) && $stable(req_q), "state moved without a request")
	`ERC_ASSERT(a_press_sets_bit, fire && item.kind == KIND_PRESS && press_ok |=> state_q == ST_DETERMINE && req_q[$past(pidx)], "press did not register")
	`ERC_ASSERT(a_open_clears_bit, fire && res.start_timer |=> !req_q[$past(cur_idx)], "door opening left floor requested")
	`ERC_ASSERT(a_stop_on_request, res.command == CMD_STOP |-> req_q[cur_idx], "stop without a request at floor")

endmodule
`default_nettype wire

// ===== hw/rtl/elevator_request_controller_core.sv =====
// A request passes through the input register, then the result register, on its way to the result.
// Throughput: one request per cycle while the output is not stalled; the event logic runs in a single pass.
// Stalls on the output hold the result register and then the input register.
// Reset (arst_n low, asynchronous): no pending floor requests, controller idle,
// both pipeline stages empty.
`default_nettype none
module elevator_request_controller_core #(
	parameter int FLOORS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [4:0] pressed_floor, [9:5] current_floor, [10] direction_down, [15:11] zero (not checked)
	input  wire logic [15:0] s_axis_tdata,
	// [2:0] kind
	input  wire logic [2:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [2:0] command, [7:3] target_floor, [12:8] release_floor, [13] start_timer,
	// [14] stop_timer, [15] zero
	output logic [15:0]      m_axis_tdata
);
	import erc_pkg::*;

	logic        valid_s1;
	logic        valid_s2;
	erc_item_t   item_s1;
	erc_result_t res_s2;
	erc_result_t res;
	logic        adv;
	logic        fire;

	assign adv           = !valid_s2 || m_axis_tready;
	assign fire          = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;
	assign m_axis_tvalid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.kind           <= s_axis_tuser;
			item_s1.pressed_floor  <= s_axis_tdata[4:0];
			item_s1.current_floor  <= s_axis_tdata[9:5];
			item_s1.direction_down <= s_axis_tdata[10];
		end
		if (fire) begin
			res_s2 <= res;
		end
	end

	erc_event_core #(
		.FLOORS(FLOORS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.res    (res)
	);

	assign m_axis_tdata = {1'b0, res_s2.stop_timer, res_s2.start_timer,
	                       res_s2.release_floor, res_s2.target_floor, res_s2.command};

endmodule
`default_nettype wire
